// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on i_clk.
`define SDRE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk.
`define SDRE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sdre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdre_pkg
// Shared widths, reset values and register codes of the dark run extractor.
// ----------------------------------------------------------------------------
package sdre_pkg;

    localparam int PIX_W      = 8;
    localparam int FIELD_W    = 12;
    localparam int COORD_W    = 29;
    localparam int DIM_REG_W  = 13;
    localparam int THR_W      = 8;
    localparam int SCALE_W    = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_DIM_DEF = 4096;

    localparam int COORD_MAX = 268435455;
    localparam int COORD_MIN = -268435456;

    localparam logic [DIM_REG_W-1:0] WIDTH_RST  = 13'd4096;
    localparam logic [DIM_REG_W-1:0] HEIGHT_RST = 13'd4096;
    localparam logic [THR_W-1:0]     THR_RST    = 8'd128;
    localparam logic [SCALE_W-1:0]   SCALE_RST  = 16'd5014;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH      = 4'd0,
        CFG_IMAGE_HEIGHT     = 4'd1,
        CFG_DARK_THRESHOLD   = 4'd2,
        CFG_LINE_WIDTH_SCALE = 4'd3
    } t_cfg_reg;

endpackage

// ===== rtl/sdre_pix_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdre_pix_if
// Pixel stream channel: one grayscale pixel per beat.
// ----------------------------------------------------------------------------
interface sdre_pix_if import sdre_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ===== rtl/sdre_seg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdre_seg_if
// Segment channel: one dark run per beat, columns, row and centred coordinates.
// ----------------------------------------------------------------------------
interface sdre_seg_if import sdre_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [FIELD_W-1:0]        start_col;
    logic [FIELD_W-1:0]        end_col;
    logic [FIELD_W-1:0]        seg_row;
    logic signed [COORD_W-1:0] x_start_mm;
    logic signed [COORD_W-1:0] x_end_mm;
    logic signed [COORD_W-1:0] y_mm;

    modport source (output valid, output start_col, output end_col, output seg_row,
                    output x_start_mm, output x_end_mm, output y_mm, input ready);
    modport sink   (input valid, input start_col, input end_col, input seg_row,
                    input x_start_mm, input x_end_mm, input y_mm, output ready);
endinterface

// ===== rtl/sdre_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdre_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface sdre_cfg_if import sdre_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/scanline_dark_run_extractor.sv =====
`timescale 1ns / 1ps
// A closed run passes the run stage register, then the output register, to o_seg.
// Throughput: one pixel per cycle unless o_seg stalls, set by the run tracker plus
//   coordinate stage (three parallel multiplies), each between two register stages.
// Reset: synchronous, active low; clears counters, run flag and stage valids and
//   restores the configuration registers to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
// scanline_dark_run_extractor
// Segments a raster pixel stream into dark runs per row and emits each run with
// its columns, row and image-centred coordinates scaled by the line width.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scanline_dark_run_extractor import sdre_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdre_cfg_if.sink   i_cfg,
    sdre_pix_if.sink   i_pix,
    sdre_seg_if.source o_seg
);

    // Counter width covers 0..MAX_DIM-1, dimension width covers 1..MAX_DIM.
    localparam int CW   = $clog2(MAX_DIM);
    localparam int DW   = $clog2(MAX_DIM + 1);
    localparam int CMPW = (DW > DIM_REG_W) ? DW : DIM_REG_W;
    // Signed difference 2*pos - size, and the product with the Q0.16 scale.
    localparam int MW   = DW + 2;
    localparam int PW   = (MW + SCALE_W + 1 > COORD_W + 1) ? MW + SCALE_W + 1 : COORD_W + 1;

    localparam logic signed [PW-1:0] CoordMax = PW'(COORD_MAX);
    localparam logic signed [PW-1:0] CoordMin = PW'(COORD_MIN);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_REG_W-1:0] r_width;
    logic [DIM_REG_W-1:0] r_height;
    logic [THR_W-1:0]     r_thresh;
    logic [SCALE_W-1:0]   r_scale;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_thresh <= THR_RST;
            r_scale  <= SCALE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_IMAGE_WIDTH:      r_width  <= i_cfg.data[DIM_REG_W-1:0];
                CFG_IMAGE_HEIGHT:     r_height <= i_cfg.data[DIM_REG_W-1:0];
                CFG_DARK_THRESHOLD:   r_thresh <= i_cfg.data[THR_W-1:0];
                CFG_LINE_WIDTH_SCALE: r_scale  <= i_cfg.data[SCALE_W-1:0];
                default: begin
                    // Unknown index: drop the write.
                end
            endcase
        end
    end

    // Clamp a size register to 1..MAX_DIM.
    function automatic logic [DW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
        logic [CMPW-1:0] v_ext;
        v_ext = CMPW'(v);
        if (v_ext == '0) begin
            clamp_dim = DW'(1);
        end else if (v_ext > CMPW'(MAX_DIM)) begin
            clamp_dim = DW'(MAX_DIM);
        end else begin
            clamp_dim = DW'(v_ext);
        end
    endfunction

    logic [DW-1:0] w_dim;
    logic [DW-1:0] h_dim;

    assign w_dim = clamp_dim(r_width);
    assign h_dim = clamp_dim(r_height);

    // ------------------------------------------------------------------
    // Handshake: the coordinate stage advances when its output slot is free
    // or being taken; the run stage advances when its slot is free or moves on.
    // ------------------------------------------------------------------
    logic r_s1_vld;
    logic r_o_vld;
    logic out_en;
    logic s1_en;
    logic pix_acc;

    assign out_en      = !r_o_vld || o_seg.ready;
    assign s1_en       = !r_s1_vld || out_en;
    assign i_pix.ready = s1_en;
    assign pix_acc     = i_pix.valid && s1_en;

    // ------------------------------------------------------------------
    // Run tracker: column/row counters and the open-run flag
    // ------------------------------------------------------------------
    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic          r_in_run;
    logic [CW-1:0] r_run_start;

    logic [CW-1:0] n_col;
    logic [CW-1:0] n_row;
    logic          n_in_run;
    logic [CW-1:0] n_run_start;

    logic          dark;
    logic          col_last;
    logic          row_last;
    logic          emit;
    logic [CW-1:0] seg_start;
    logic [CW-1:0] seg_end;

    assign dark     = i_pix.pixel < r_thresh;
    assign col_last = DW'(r_col) >= (w_dim - DW'(1));
    assign row_last = DW'(r_row) >= (h_dim - DW'(1));

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_in_run    = r_in_run;
        n_run_start = r_run_start;
        emit        = 1'b0;
        seg_start   = r_col;
        seg_end     = r_col;

        if (dark && !r_in_run) begin
            if (col_last) begin
                // Lone dark pixel at the row end: one-pixel segment.
                emit = 1'b1;
            end else begin
                n_run_start = r_col;
                n_in_run    = 1'b1;
            end
        end else if (r_in_run && (!dark || col_last)) begin
            // Close the run on the first light pixel or at the row end.
            emit      = 1'b1;
            seg_start = r_run_start;
            seg_end   = dark ? r_col : r_col - CW'(1);
            n_in_run  = 1'b0;
        end

        if (col_last) begin
            n_col    = '0;
            n_in_run = 1'b0;
            n_row    = row_last ? '0 : r_row + CW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_in_run    <= 1'b0;
            r_run_start <= '0;
        end else if (pix_acc) begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_in_run    <= n_in_run;
            r_run_start <= n_run_start;
        end
    end

    // ------------------------------------------------------------------
    // Run stage register: closed segment waiting for coordinate math
    // ------------------------------------------------------------------
    logic [CW-1:0] r_s1_start;
    logic [CW-1:0] r_s1_end;
    logic [CW-1:0] r_s1_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_en) begin
            r_s1_vld <= pix_acc && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en && pix_acc && emit) begin
            r_s1_start <= seg_start;
            r_s1_end   <= seg_end;
            r_s1_row   <= r_row;
        end
    end

    // ------------------------------------------------------------------
    // Coordinate stage: (2*pos - size) * scale, negated for y, saturated
    // ------------------------------------------------------------------
    function automatic logic [COORD_W-1:0] centred(
        input logic [CW-1:0]      pos,
        input logic [DW-1:0]      size,
        input logic               flip,
        input logic [SCALE_W-1:0] scale
    );
        logic signed [MW-1:0]        d;
        logic signed [SCALE_W:0]     sc;
        logic signed [PW-1:0]        v;
        d  = $signed(MW'({pos, 1'b0})) - $signed(MW'(size));
        if (flip) begin
            d = -d;
        end
        sc = $signed({1'b0, scale});
        v  = PW'(d) * PW'(sc);
        if (v > CoordMax) begin
            v = CoordMax;
        end else if (v < CoordMin) begin
            v = CoordMin;
        end
        centred = v[COORD_W-1:0];
    endfunction

    logic [FIELD_W-1:0] r_o_start;
    logic [FIELD_W-1:0] r_o_end;
    logic [FIELD_W-1:0] r_o_row;
    logic [COORD_W-1:0] r_o_xs;
    logic [COORD_W-1:0] r_o_xe;
    logic [COORD_W-1:0] r_o_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_en) begin
            r_o_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_s1_vld) begin
            r_o_start <= FIELD_W'(r_s1_start);
            r_o_end   <= FIELD_W'(r_s1_end);
            r_o_row   <= FIELD_W'(r_s1_row);
            r_o_xs    <= centred(r_s1_start, w_dim, 1'b0, r_scale);
            r_o_xe    <= centred(r_s1_end, w_dim, 1'b0, r_scale);
            r_o_y     <= centred(r_s1_row, h_dim, 1'b1, r_scale);
        end
    end

    assign o_seg.valid      = r_o_vld;
    assign o_seg.start_col  = r_o_start;
    assign o_seg.end_col    = r_o_end;
    assign o_seg.seg_row    = r_o_row;
    assign o_seg.x_start_mm = $signed(r_o_xs);
    assign o_seg.x_end_mm   = $signed(r_o_xe);
    assign o_seg.y_mm       = $signed(r_o_y);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An open run always started at an earlier column of the current row.
    `SDRE_ASSERT_IMP(a_run_start_behind, r_in_run, r_run_start < r_col, "open run not behind column")
    // A waiting segment holds while the output slot is blocked.
    `SDRE_ASSERT_NXT(a_s1_hold, r_s1_vld && !out_en, r_s1_vld && $stable(r_s1_start) && $stable(r_s1_end), "segment lost under stall")
    // A segment never ends before it starts.
    `SDRE_ASSERT_IMP(a_seg_order, r_s1_vld, r_s1_end >= r_s1_start, "segment end before start")

endmodule

// ===== test/sdre_run_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdre_run_checker
// Watches the configuration, pixel and segment channels of the dark run
// extractor, predicts every segment from the accepted pixels and compares each
// segment beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sdre_run_checker import sdre_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sdre_cfg_if  i_cfg,
    sdre_pix_if  i_pix,
    sdre_seg_if  i_seg,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_runs_seen
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [FIELD_W-1:0]        start_col;
        logic [FIELD_W-1:0]        end_col;
        logic [FIELD_W-1:0]        seg_row;
        logic signed [COORD_W-1:0] x_start;
        logic signed [COORD_W-1:0] x_end;
        logic signed [COORD_W-1:0] y;
    } t_dark_run;

    // Register copies, raw as written.
    logic [DIM_REG_W-1:0] width_raw;
    logic [DIM_REG_W-1:0] height_raw;
    logic [THR_W-1:0]     thr;
    logic [SCALE_W-1:0]   scale_q16;

    // Raster position and open run.
    int unsigned col_pos;
    int unsigned row_pos;
    bit          run_open;
    int unsigned run_first;

    t_dark_run runs_due[$];
    t_dark_run got;
    t_dark_run want;
    int        fail_total;
    int        runs_total;

    function automatic int unsigned dim_used(logic [DIM_REG_W-1:0] raw);
        if (raw == '0) return 1;
        if (raw > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(raw);
    endfunction

    // Offset from the image center in half pixels, times the line width, saturated.
    function automatic logic signed [COORD_W-1:0] centre_mm(int unsigned pos,
                                                            int unsigned size, bit flip);
        longint offset;
        longint scaled;
        offset = 2 * longint'(pos) - longint'(size);
        if (flip) offset = -offset;
        scaled = offset * longint'(scale_q16);
        if (scaled > COORD_MAX) scaled = COORD_MAX;
        if (scaled < COORD_MIN) scaled = COORD_MIN;
        return scaled[COORD_W-1:0];
    endfunction

    task automatic scan_pixel(logic [PIX_W-1:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned s_col;
        int unsigned e_col;
        bit          dark;
        bit          last;
        bit          emit;
        t_dark_run   run;
        w     = dim_used(width_raw);
        h     = dim_used(height_raw);
        dark  = pix < thr;
        last  = col_pos >= w - 1;
        emit  = 1'b0;
        s_col = 0;
        e_col = 0;
        if (dark && !run_open) begin
            if (last) begin
                s_col = col_pos;
                e_col = col_pos;
                emit  = 1'b1;
            end else begin
                run_first = col_pos;
                run_open  = 1'b1;
            end
        end else if (run_open && (!dark || last)) begin
            s_col    = run_first;
            e_col    = dark ? col_pos : col_pos - 1;
            emit     = 1'b1;
            run_open = 1'b0;
        end
        if (emit) begin
            run.start_col = s_col[FIELD_W-1:0];
            run.end_col   = e_col[FIELD_W-1:0];
            run.seg_row   = row_pos[FIELD_W-1:0];
            run.x_start   = centre_mm(s_col, w, 1'b0);
            run.x_end     = centre_mm(e_col, w, 1'b0);
            run.y         = centre_mm(row_pos, h, 1'b1);
            runs_due      = {runs_due, run};
        end
        if (last) begin
            col_pos  = 0;
            run_open = 1'b0;
            row_pos  = (row_pos >= h - 1) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_raw  = WIDTH_RST;
            height_raw = HEIGHT_RST;
            thr        = THR_RST;
            scale_q16  = SCALE_RST;
            col_pos    = 0;
            row_pos    = 0;
            run_open   = 1'b0;
            run_first  = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_IMAGE_WIDTH:      width_raw  = i_cfg.data[DIM_REG_W-1:0];
                    CFG_IMAGE_HEIGHT:     height_raw = i_cfg.data[DIM_REG_W-1:0];
                    CFG_DARK_THRESHOLD:   thr        = i_cfg.data[THR_W-1:0];
                    CFG_LINE_WIDTH_SCALE: scale_q16  = i_cfg.data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) scan_pixel(i_pix.pixel);
            if (i_seg.valid && i_seg.ready) begin
                got.start_col = i_seg.start_col;
                got.end_col   = i_seg.end_col;
                got.seg_row   = i_seg.seg_row;
                got.x_start   = i_seg.x_start_mm;
                got.x_end     = i_seg.x_end_mm;
                got.y         = i_seg.y_mm;
                runs_total++;
                if (runs_due.size() == 0) begin
                    if (fail_total < MAX_REPORTS)
                        $display("%0t: unexpected segment col %0d..%0d row %0d",
                                 $time, got.start_col, got.end_col, got.seg_row);
                    fail_total++;
                end else begin
                    want = runs_due.pop_front();
                    if (got !== want) begin
                        if (fail_total < MAX_REPORTS) begin
                            $display("%0t: segment mismatch", $time);
                            $display("  expected col %0d..%0d row %0d x %0d..%0d y %0d",
                                     want.start_col, want.end_col, want.seg_row,
                                     want.x_start, want.x_end, want.y);
                            $display("  actual   col %0d..%0d row %0d x %0d..%0d y %0d",
                                     got.start_col, got.end_col, got.seg_row,
                                     got.x_start, got.x_end, got.y);
                        end
                        fail_total++;
                    end
                end
            end
        end
        o_mismatches <= fail_total;
        o_pending    <= runs_due.size();
        o_runs_seen  <= runs_total;
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the scanline dark run extractor. Streams directed and random
// pixel images through several register settings with random gaps and stalls
// on both channels, one long segment back-pressure stretch, and leaves the
// segment prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module testbench import sdre_pkg::*; ;

    localparam int HALF_PERIOD   = 1;
    localparam int RESET_CYCLES  = 2;
    localparam int SETTLE_CYCLES = 8;       // segments pass the run stage and output registers
    localparam int HOLD_CYCLES   = 300;     // long segment back-pressure stretch
    localparam int RANDOM_PIXELS = 650;
    localparam int MAX_IDLE      = 14;
    localparam int LIMIT_NS      = 1_000_000;

    // Index past the register list; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd15;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sdre_cfg_if cfg_bus ();
    sdre_pix_if pixel_bus ();
    sdre_seg_if seg_bus ();

    int mismatch_count;
    int runs_pending;
    int runs_seen;

    // Stimulus bookkeeping shared by the driving processes.
    logic [THR_W-1:0] cur_thr = THR_RST;
    int               idle_cap = MAX_IDLE;
    bit               hold_req = 1'b0;
    int               pixels_sent = 0;
    int               settings_used = 1;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    scanline_dark_run_extractor u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pixel_bus),
        .o_seg   (seg_bus)
    );

    sdre_run_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_bus),
        .i_pix        (pixel_bus),
        .i_seg        (seg_bus),
        .o_mismatches (mismatch_count),
        .o_pending    (runs_pending),
        .o_runs_seen  (runs_seen)
    );

    // ------------------------------------------------------------------------
    // Pixel channel: optional gap, then hold the beat until it is taken. Leave
    // valid high between back-to-back beats so it is never dropped and raised
    // in the same step.
    // ------------------------------------------------------------------------
    task automatic send_pixel(logic [PIX_W-1:0] value);
        int gap;
        gap = $urandom_range(idle_cap, 0);
        if (gap > 0) begin
            pixel_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pixel_bus.valid <= 1'b1;
        pixel_bus.pixel <= value;
        do @(posedge i_clk); while (!pixel_bus.ready);
        pixels_sent++;
    endtask

    task automatic close_pixels();
        pixel_bus.valid <= 1'b0;
    endtask

    // Register writes stay back to back; close_cfg drops valid after the last.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        if (idx == CFG_DARK_THRESHOLD) cur_thr = value[THR_W-1:0];
    endtask

    task automatic close_cfg();
        cfg_bus.valid <= 1'b0;
        settings_used++;
    endtask

    // Wait out every predicted segment, then give the pipeline time to empty
    // of pixels that close no run before the registers change.
    task automatic settle();
        while (runs_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Pick a pixel on the requested side of the current threshold.
    function automatic logic [PIX_W-1:0] shade(bit want_dark);
        if (want_dark && cur_thr != 0) return PIX_W'($urandom_range(cur_thr - 1, 0));
        return PIX_W'($urandom_range(255, cur_thr));
    endfunction

    // Size register value: mostly small images, now and then the edges.
    function automatic logic [CFG_DATA_W-1:0] pick_dim(int typical_max);
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'(MAX_DIM_DEF);
            3:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(typical_max, 1));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_thr();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return CFG_DATA_W'(8'hFF);
            2:       return CFG_DATA_W'(1);
            3:       return CFG_DATA_W'($urandom_range(255, 0));
            default: return CFG_DATA_W'($urandom_range(220, 40));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_scale();
        case ($urandom_range(5, 0))
            0:       return '0;
            1:       return '1;
            2:       return SCALE_RST;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Segment sink: random stall before each beat, one long hold-off on
    // request while the pixel side keeps pushing, so the block backs up.
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        bit hold_done;
        hold_done = 1'b0;
        seg_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req && !hold_done) begin
                seg_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                stall = $urandom_range(idle_cap, 0);
                if (stall > 0) begin
                    seg_bus.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            seg_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(seg_bus.valid && seg_bus.ready));
        end
    end

    // ------------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------------
    initial begin
        int          random_pixels;
        int          count;
        int          run_left;
        bit          want_dark;
        bit          structured;
        logic [7:0]  value;

        i_rst_n         <= 1'b0;
        cfg_bus.valid   <= 1'b0;
        cfg_bus.index   <= CFG_IMAGE_WIDTH;
        cfg_bus.data    <= '0;
        pixel_bus.valid <= 1'b0;
        pixel_bus.pixel <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: threshold 128 exactly is light, 127 dark; leave a
        // run open at the end of the stretch.
        send_pixel(8'h00);
        send_pixel(8'h7F);
        send_pixel(8'h80);
        send_pixel(8'hFF);
        send_pixel(8'h7F);
        send_pixel(8'hAA);
        send_pixel(8'h55);
        send_pixel(8'h00);
        close_pixels();
        settle();

        // Width zero clamps to one: every pixel is the last column. The open
        // run closes on a dark last pixel, then lone dark pixels at the last
        // column come out as one-pixel segments. Threshold 255 keeps 255 light.
        write_reg(CFG_IMAGE_WIDTH, '0);
        write_reg(CFG_IMAGE_HEIGHT, 16'd2);
        write_reg(CFG_DARK_THRESHOLD, 16'd255);
        write_reg(CFG_LINE_WIDTH_SCALE, '1);
        write_reg(CFG_SPARE_IDX, '1);
        close_cfg();
        send_pixel(8'h00);
        send_pixel(8'hFE);
        send_pixel(8'hFF);
        send_pixel(8'h01);
        close_pixels();
        settle();

        // Oversize width and zero height clamp; threshold zero makes nothing dark.
        write_reg(CFG_IMAGE_WIDTH, '1);
        write_reg(CFG_IMAGE_HEIGHT, '0);
        write_reg(CFG_DARK_THRESHOLD, '0);
        write_reg(CFG_LINE_WIDTH_SCALE, '0);
        close_cfg();
        send_pixel(8'h00);
        send_pixel(8'hFF);
        close_pixels();
        settle();

        // Shrink the width under the current column: that pixel becomes the last.
        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        write_reg(CFG_IMAGE_HEIGHT, 16'(MAX_DIM_DEF));
        write_reg(CFG_DARK_THRESHOLD, 16'd1);
        write_reg(CFG_LINE_WIDTH_SCALE, '1);
        close_cfg();
        send_pixel(8'h00);
        close_pixels();
        settle();

        // Full width from column zero at full scale: most negative x.
        write_reg(CFG_IMAGE_WIDTH, 16'(MAX_DIM_DEF));
        close_cfg();
        send_pixel(8'h00);
        send_pixel(8'h00);
        send_pixel(8'h80);
        close_pixels();
        settle();

        // Random settings phases. The first one is the back-pressure phase:
        // small rows, lots of short runs, no gaps on the pixel side.
        random_pixels = 0;
        want_dark     = 1'b0;
        run_left      = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            if (random_pixels == 0) begin
                write_reg(CFG_IMAGE_WIDTH, 16'd9);
                write_reg(CFG_IMAGE_HEIGHT, 16'd3);
                write_reg(CFG_DARK_THRESHOLD, 16'd128);
                close_cfg();
                idle_cap   = 0;
                hold_req   = 1'b1;
                structured = 1'b1;
                count      = 80;
            end else begin
                if ($urandom_range(1, 0)) write_reg(CFG_IMAGE_WIDTH, pick_dim(24));
                if ($urandom_range(1, 0)) write_reg(CFG_IMAGE_HEIGHT, pick_dim(8));
                if ($urandom_range(1, 0)) write_reg(CFG_DARK_THRESHOLD, pick_thr());
                if ($urandom_range(1, 0)) write_reg(CFG_LINE_WIDTH_SCALE, pick_scale());
                if ($urandom_range(5, 0) == 0)
                    write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
                close_cfg();
                idle_cap   = ($urandom_range(3, 0) == 0) ? 0 : MAX_IDLE;
                structured = $urandom_range(4, 0) != 0;
                count      = $urandom_range(60, 20);
            end
            for (int k = 0; k < count; k++) begin
                if (structured) begin
                    // Alternate dark and light stretches; now and then a long one.
                    if (run_left == 0) begin
                        want_dark = !want_dark;
                        run_left  = ($urandom_range(7, 0) == 0) ? $urandom_range(30, 8)
                                                                 : $urandom_range(5, 1);
                    end
                    run_left--;
                    value = shade(want_dark);
                end else begin
                    value = PIX_W'($urandom_range(255, 0));
                end
                send_pixel(value);
                random_pixels++;
            end
            close_pixels();
            settle();
        end

        $display("Streamed %0d pixels through %0d register settings; %0d segments compared.",
                 pixels_sent, settings_used, runs_seen);
        $display("Included clamped sizes, mid-row resizes and a %0d-cycle segment stall.",
                 HOLD_CYCLES);
        if (mismatch_count == 0 && runs_pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Hard stop if the run hangs on a handshake.
    initial begin
        #(LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sdre_pkg.sv
rtl/sdre_pix_if.sv
rtl/sdre_seg_if.sv
rtl/sdre_cfg_if.sv
rtl/scanline_dark_run_extractor.sv
test/sdre_run_checker.sv
test/testbench.sv
